// ----- hdl/pearson_correlation_engine_top_assert.svh -----
// ----------------------------------------------------------------------------
// pearson_correlation_engine_top_assert.svh
// Assertion macros for the correlation engine checkers.
// ----------------------------------------------------------------------------
`ifndef PEARSON_CORRELATION_ENGINE_TOP_ASSERT_SVH
`define PEARSON_CORRELATION_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PCE_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("pce assertion failed");

// next-cycle implication
`define PCE_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("pce assertion failed");

`endif

// ----- hdl/pce_pkg.sv -----
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants of the correlation engine.
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int QDEPTH   = 2;
	localparam int RBITS    = 17;
	localparam int PAIRS_W  = 17;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NXX,
		S_SX2,
		S_NYY,
		S_SY2,
		S_NXY,
		S_SXY,
		S_BASE,
		S_RHS,
		S_SQ,
		S_LHS,
		S_FIN,
		S_OUT
	} back_state_t;

	typedef struct packed {
		logic signed [15:0]   correlation;
		logic [PAIRS_W-1:0]   pairs_used;
		logic                 degenerate;
	} pce_result_t;

endpackage

// ----- hdl/pce_if.sv -----
// ----------------------------------------------------------------------------
// pce_if
// Valid/ready channels of the correlation engine.
// ----------------------------------------------------------------------------
interface pce_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_value;
	logic signed [15:0] y_value;
	logic               missing;
	logic               last_pair;
	modport source (output valid, output x_value, output y_value, output missing,
		output last_pair, input ready);
	modport sink (input valid, input x_value, input y_value, input missing,
		input last_pair, output ready);
endinterface

interface pce_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] correlation;
	logic [16:0]        pairs_used;
	logic               degenerate;
	modport source (output valid, output correlation, output pairs_used,
		output degenerate, input ready);
	modport sink (input valid, input correlation, input pairs_used,
		input degenerate, output ready);
endinterface

interface pce_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/pce_fifo.sv -----
// ----------------------------------------------------------------------------
// pce_fifo
// Short snapshot queue between front and back.
// ----------------------------------------------------------------------------
module pce_fifo import pce_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNTW = $clog2(QDEPTH + 1);

	logic [W-1:0]    mem_q [QDEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign full  = (cnt_q == CNTW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- hdl/pce_mul.sv -----
// ----------------------------------------------------------------------------
// pce_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pce_mul import pce_pkg::*; #(
	parameter int PW = 8,
	parameter int BW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [PW-1:0] p
);
	logic [PW-1:0] a_q, acc_q;
	logic [BW-1:0] b_q;
	logic          busy_q;

	assign done = busy_q && (b_q == '0);
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[PW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end
endmodule

// ----- hdl/pce_front.sv -----
// ----------------------------------------------------------------------------
// pce_front
// Takes pairs, accumulates count and sums, queues a snapshot on last pair.
// ----------------------------------------------------------------------------
module pce_front import pce_pkg::*; #(
	parameter int MAX_LENGTH = 65536,
	parameter int CW         = 17,
	parameter int SNW        = 228
) (
	input  logic           clk,
	input  logic           arst_n,
	pce_cfg_if.sink        cfg,
	pce_in_if.sink         pair_in,
	output logic           push,
	output logic [SNW-1:0] snap,
	input  logic           full
);
	localparam int SW  = CW + 16;
	localparam int XW  = CW + 31;
	localparam int PXW = CW + 32;

	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic signed [SW-1:0]  sx_q, sy_q;
	logic [XW-1:0]         sxx_q, syy_q;
	logic signed [PXW-1:0] sxy_q;

	logic signed [16:0]    xe, ye;
	logic signed [33:0]    pxx, pyy, pxy;
	logic                  keep, accept;
	logic [CW-1:0]         n_cnt;
	logic signed [SW-1:0]  n_sx, n_sy;
	logic [XW-1:0]         n_sxx, n_syy;
	logic signed [PXW-1:0] n_sxy;

	assign cfg.ready     = 1'b1;
	assign pair_in.ready = !full;
	assign accept        = pair_in.valid && pair_in.ready;

	always_comb begin
		xe     = neg_q ? -{pair_in.x_value[15], pair_in.x_value}
		                : {pair_in.x_value[15], pair_in.x_value};
		ye     = {pair_in.y_value[15], pair_in.y_value};
		pxx    = xe * xe;
		pyy    = ye * ye;
		pxy    = xe * ye;
		keep   = !pair_in.missing && (cnt_q < CW'(MAX_LENGTH));
		n_cnt  = cnt_q;
		n_sx   = sx_q;
		n_sy   = sy_q;
		n_sxx  = sxx_q;
		n_syy  = syy_q;
		n_sxy  = sxy_q;
		if (keep) begin
			n_cnt = cnt_q + 1'b1;
			n_sx  = sx_q + SW'(xe);
			n_sy  = sy_q + SW'(ye);
			n_sxx = sxx_q + XW'(pxx[32:0]);
			n_syy = syy_q + XW'(pyy[32:0]);
			n_sxy = sxy_q + PXW'(pxy);
		end
	end

	assign push = accept && pair_in.last_pair;
	assign snap = {n_cnt, n_sx, n_sy, n_sxx, n_syy, n_sxy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else begin
			if (cfg.valid) begin
				neg_q <= cfg.data;
			end
			if (accept) begin
				if (pair_in.last_pair) begin
					cnt_q <= '0;
					sx_q  <= '0;
					sy_q  <= '0;
					sxx_q <= '0;
					syy_q <= '0;
					sxy_q <= '0;
				end else begin
					cnt_q <= n_cnt;
					sx_q  <= n_sx;
					sy_q  <= n_sy;
					sxx_q <= n_sxx;
					syy_q <= n_syy;
					sxy_q <= n_sxy;
				end
			end
		end
	end
endmodule

// ----- hdl/pce_back.sv -----
// ----------------------------------------------------------------------------
// pce_back
// Sequencer for variances, covariance and the bitwise search for r.
// ----------------------------------------------------------------------------
module pce_back import pce_pkg::*; #(
	parameter int CW  = 17,
	parameter int SNW = 228
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [SNW-1:0] snap,
	input  logic           empty,
	output logic           pop,
	pce_out_if.source      result_out
);
	localparam int SW  = CW + 16;
	localparam int XW  = CW + 31;
	localparam int PXW = CW + 32;
	localparam int PW  = 4 * CW + 98;
	localparam int BW  = 2 * CW + 33;

	back_state_t state_q, state_d;
	logic        started_q;

	logic [CW-1:0]         n_q;
	logic signed [SW-1:0]  sx_q, sy_q;
	logic [XW-1:0]         sxx_q, syy_q;
	logic signed [PXW-1:0] sxy_q;
	logic [PW-1:0]         t_q, vx_q, vy_q, base_q, rhs_q, mag_q;
	logic                  neg_q;
	logic [4:0]            bit_q;
	logic [RBITS-1:0]      r_q, c_q;
	logic [2*RBITS-1:0]    csq_q;
	pce_result_t           res_q;

	logic [CW-1:0]         s_n;
	logic signed [SW-1:0]  s_sx, s_sy;
	logic [XW-1:0]         s_sxx, s_syy;
	logic signed [PXW-1:0] s_sxy;
	logic [CW+PAIRS_W-1:0] s_nx;

	logic [SW-1:0]  ax, ay;
	logic [PXW-1:0] axy;
	logic [PW-1:0]  diff;
	logic           mul_start, mul_done;
	logic [PW-1:0]  mul_a, mul_p;
	logic [BW-1:0]  mul_b;
	logic [RBITS-1:0] c_next;
	logic           sp, sq;

	assign {s_n, s_sx, s_sy, s_sxx, s_syy, s_sxy} = snap;
	assign s_nx = {{PAIRS_W{1'b0}}, s_n};

	assign ax     = sx_q[SW-1] ? SW'(-sx_q) : SW'(sx_q);
	assign ay     = sy_q[SW-1] ? SW'(-sy_q) : SW'(sy_q);
	assign axy    = sxy_q[PXW-1] ? PXW'(-sxy_q) : PXW'(sxy_q);
	assign diff   = t_q - mul_p;
	assign c_next = r_q | (RBITS'(1) << bit_q);
	assign sp     = sxy_q[PXW-1];
	assign sq     = sx_q[SW-1] ^ sy_q[SW-1];

	pce_mul #(.PW(PW), .BW(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start) begin
				started_q <= 1'b1;
			end else if (mul_done) begin
				started_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = (s_n == '0) ? S_OUT : S_NXX;
				end
			end
			S_NXX: begin
				mul_a = PW'(sxx_q);
				mul_b = BW'(n_q);
				if (mul_done) state_d = S_SX2;
			end
			S_SX2: begin
				mul_a = PW'(ax);
				mul_b = BW'(ax);
				if (mul_done) state_d = S_NYY;
			end
			S_NYY: begin
				mul_a = PW'(syy_q);
				mul_b = BW'(n_q);
				if (mul_done) state_d = S_SY2;
			end
			S_SY2: begin
				mul_a = PW'(ay);
				mul_b = BW'(ay);
				if (mul_done) begin
					state_d = ((vx_q == '0) || (diff == '0)) ? S_OUT : S_NXY;
				end
			end
			S_NXY: begin
				mul_a = PW'(axy);
				mul_b = BW'(n_q);
				if (mul_done) state_d = S_SXY;
			end
			S_SXY: begin
				mul_a = PW'(ax);
				mul_b = BW'(ay);
				if (mul_done) state_d = S_BASE;
			end
			S_BASE: begin
				mul_a = vx_q;
				mul_b = BW'(vy_q);
				if (mul_done) state_d = S_RHS;
			end
			S_RHS: begin
				mul_a = mag_q;
				mul_b = BW'(mag_q);
				if (mul_done) state_d = S_SQ;
			end
			S_SQ: begin
				state_d = S_LHS;
			end
			S_LHS: begin
				mul_a = base_q;
				mul_b = BW'(csq_q);
				if (mul_done) state_d = (bit_q == '0) ? S_FIN : S_SQ;
			end
			S_FIN: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (result_out.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if ((state_q != S_IDLE) && (state_q != S_SQ) && (state_q != S_FIN) &&
			(state_q != S_OUT) && !started_q) begin
			mul_start = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					n_q   <= s_n;
					sx_q  <= s_sx;
					sy_q  <= s_sy;
					sxx_q <= s_sxx;
					syy_q <= s_syy;
					sxy_q <= s_sxy;
					r_q   <= '0;
					bit_q <= 5'(RBITS - 1);
					res_q.pairs_used  <= s_nx[PAIRS_W-1:0];
					res_q.correlation <= '0;
					res_q.degenerate  <= 1'b1;
				end
			end
			S_NXX, S_NYY, S_NXY: begin
				if (mul_done) t_q <= mul_p;
			end
			S_SX2: begin
				if (mul_done) vx_q <= diff;
			end
			S_SY2: begin
				if (mul_done) vy_q <= diff;
			end
			S_SXY: begin
				if (mul_done) begin
					if (sp != sq) begin
						mag_q <= t_q + mul_p;
						neg_q <= sp;
					end else if (t_q >= mul_p) begin
						mag_q <= diff;
						neg_q <= sp;
					end else begin
						mag_q <= mul_p - t_q;
						neg_q <= !sp;
					end
				end
			end
			S_BASE: begin
				if (mul_done) base_q <= mul_p;
			end
			S_RHS: begin
				if (mul_done) rhs_q <= mul_p << 30;
			end
			S_SQ: begin
				c_q   <= c_next;
				csq_q <= c_next * c_next;
			end
			S_LHS: begin
				if (mul_done) begin
					if (mul_p <= rhs_q) r_q <= c_q;
					bit_q <= bit_q - 1'b1;
				end
			end
			S_FIN: begin
				res_q.degenerate <= 1'b0;
				if (neg_q) begin
					res_q.correlation <= 16'(-r_q);
				end else if (r_q > RBITS'(32767)) begin
					res_q.correlation <= 16'sd32767;
				end else begin
					res_q.correlation <= 16'(r_q);
				end
			end
			default: ;
		endcase
	end

	assign result_out.valid       = (state_q == S_OUT);
	assign result_out.correlation = res_q.correlation;
	assign result_out.pairs_used  = res_q.pairs_used;
	assign result_out.degenerate  = res_q.degenerate;
endmodule

// ----- hdl/pearson_correlation_engine_top.sv -----
// ----------------------------------------------------------------------------
// pearson_correlation_engine_top
// Streaming Pearson correlation of two Q8.8 vectors, result in Q1.15.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle while the snapshot queue has room.
// A vector's result is worked out on the shared shift-add multiplier; the
// 17 search steps for r take most of its work.
// Two finished vectors may wait in the queue while the back end works.
// Reset clears sums, count, negate_first and all handshake state at once.
module pearson_correlation_engine_top import pce_pkg::*; #(
	parameter int MAX_LENGTH = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	pce_cfg_if.sink    cfg,
	pce_in_if.sink     pair_in,
	pce_out_if.source  result_out
);
	localparam int CW  = $clog2(MAX_LENGTH + 1);
	localparam int SNW = 6 * CW + 126;

	logic           push, pop, full, empty;
	logic [SNW-1:0] snap_w, snap_r;

	pce_front #(.MAX_LENGTH(MAX_LENGTH), .CW(CW), .SNW(SNW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pair_in (pair_in),
		.push    (push),
		.snap    (snap_w),
		.full    (full)
	);

	pce_fifo #(.W(SNW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (snap_w),
		.full   (full),
		.pop    (pop),
		.rdata  (snap_r),
		.empty  (empty)
	);

	pce_back #(.CW(CW), .SNW(SNW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap_r),
		.empty      (empty),
		.pop        (pop),
		.result_out (result_out)
	);
endmodule

// ----- hdl/pce_checker.sv -----
// ----------------------------------------------------------------------------
// pce_port_checker
// Port-level checks on the result channel of the correlation engine.
// ----------------------------------------------------------------------------
`include "pearson_correlation_engine_top_assert.svh"

module pce_port_checker #(
	parameter int MAX_LENGTH = 65536
) (
	input logic        clk,
	input logic        arst_n,
	input logic        o_valid,
	input logic        o_ready,
	input logic [15:0] o_corr,
	input logic [16:0] o_pairs,
	input logic        o_degen
);
	`PCE_ASSERT_NXT(a_hold, o_valid && !o_ready, o_valid && $stable(o_corr) && $stable(o_pairs) && $stable(o_degen))
	`PCE_ASSERT_IMP(a_degen_zero, o_valid && o_degen, o_corr == 16'd0)
	`PCE_ASSERT_IMP(a_few_pairs, (MAX_LENGTH < 131072) && o_valid && (o_pairs < 17'd2), o_degen)
endmodule

bind pearson_correlation_engine_top pce_port_checker #(.MAX_LENGTH(MAX_LENGTH)) u_pce_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.o_valid (result_out.valid),
	.o_ready (result_out.ready),
	.o_corr  (result_out.correlation),
	.o_pairs (result_out.pairs_used),
	.o_degen (result_out.degenerate)
);
